// ===== sv/rpps_pkg.sv =====
package rpps_pkg;

   // Field widths of one request and one response
   localparam int CMD_W     = 4;
   localparam int ELAPSED_W = 16;
   localparam int SPEED_W   = 16;
   localparam int TURBO_W   = 2;
   localparam int LEVEL_W   = 12;
   localparam int PERIOD_W  = 18;

   // Register file port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_PRESENT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENGINE_EFFECT  = 1'b1;

   // Internal widths
   localparam int TOTAL_W = 32;
   localparam int TIME_W  = 16;
   localparam int U_W     = 13;  // speed ratio to 0.2, units of 1/4096
   localparam int UU_W    = 25;  // its square
   localparam int MAG_W   = 10;  // speed magnitude below the period cutoff
   localparam int PER_W   = 24;  // magnitude times period scale
   localparam int LVL20_W = 17;  // intensity times 20
   localparam int PROD_W  = 42;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK     = 4'd0,
      CMD_TURBO    = 4'd1,
      CMD_REACTION = 4'd2,
      CMD_LIGHT    = 4'd3,
      CMD_SCRAPE   = 4'd4,
      CMD_SET_LVL  = 4'd5,
      CMD_ENG_ON   = 4'd6,
      CMD_ENG_OFF  = 4'd7,
      CMD_PAUSE    = 4'd8,
      CMD_RESUME   = 4'd9
   } cmd_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_ON   = 2'd1,
      PH_OFF  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_COMMIT
   } fsm_type;

   typedef struct packed {
      logic capture;
      logic stage1;
      logic stage2;
      logic commit;
   } ctl_type;

   localparam logic [TOTAL_W-1:0] ENDLESS_MS     = 32'hFFFF_FFFF;
   localparam logic [TIME_W-1:0]  SURFACE_OFF_MS = 16'd50;

   localparam logic [TOTAL_W-1:0] TURBO0_TOTAL = 32'd1000;
   localparam logic [TIME_W-1:0]  TURBO0_ON    = 16'd500;
   localparam logic [TOTAL_W-1:0] TURBO1_TOTAL = 32'd1500;
   localparam logic [TIME_W-1:0]  TURBO1_ON    = 16'd750;
   localparam logic [TOTAL_W-1:0] TURBO2_TOTAL = 32'd5000;
   localparam logic [TIME_W-1:0]  TURBO2_ON    = 16'd500;
   localparam logic [TIME_W-1:0]  TURBO2_OFF   = 16'd100;
   localparam logic [TOTAL_W-1:0] TURBO3_TOTAL = 32'd1000;
   localparam logic [TIME_W-1:0]  TURBO3_ON    = 16'd1000;
   localparam logic [TOTAL_W-1:0] REACT_TOTAL  = 32'd500;
   localparam logic [TIME_W-1:0]  REACT_ON     = 16'd500;
   localparam logic [TOTAL_W-1:0] LIGHT_TOTAL  = 32'd150;
   localparam logic [TIME_W-1:0]  LIGHT_ON     = 16'd150;
   localparam logic [TOTAL_W-1:0] SCRAPE_TOTAL = 32'd100;
   localparam logic [TIME_W-1:0]  SCRAPE_ON    = 16'd100;
   localparam logic [TIME_W-1:0]  NO_OFF       = 16'd0;

   // Ratio 1.0 in units of 1/4096; above it the engine period is zero
   localparam int SPEED_FULL   = 4096;
   // 1e6 / 4096 = 15625 / 64
   localparam int PERIOD_SCALE = 15625;
   localparam int PERIOD_SHIFT = 6;
   localparam int PERIOD_MAX   = 200000;
   // Squared ratio below 0.02 gives no surface pulse: 50 * uu < 2^24
   localparam int SURF_MIN_SQ  = ((1 << 24) + 49) / 50;

   function automatic logic [LVL20_W-1:0] times20(input logic [LEVEL_W-1:0] lvl);
      times20 = LVL20_W'({lvl, 4'b0000}) + LVL20_W'({lvl, 2'b00});
   endfunction

   // On time of a freshly started surface rumble: 20 * level / 256
   function automatic logic [TIME_W-1:0] surf_start_on(input logic [LEVEL_W-1:0] lvl);
      logic [LVL20_W-1:0] l20;
      l20 = times20(lvl);
      surf_start_on = TIME_W'(l20[LVL20_W-1:8]);
   endfunction

endpackage

// ===== sv/rpps_channels.sv =====
interface rpps_req_if;
   import rpps_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [CMD_W-1:0]            command;
   logic [ELAPSED_W-1:0]        elapsed_ms;
   logic signed [SPEED_W-1:0]   forward_speed;
   logic [TURBO_W-1:0]          turbo_level;
   logic [LEVEL_W-1:0]          intensity;

   modport source (
      output valid, command, elapsed_ms, forward_speed, turbo_level, intensity,
      input  ready
   );

   modport sink (
      input  valid, command, elapsed_ms, forward_speed, turbo_level, intensity,
      output ready
   );
endinterface

interface rpps_rsp_if;
   import rpps_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  motor_on;
   logic [1:0]            pattern_phase;
   logic                  surface_active;
   logic                  engine_running;
   logic                  engine_period_valid;
   logic [PERIOD_W-1:0]   engine_period_us;

   modport source (
      output valid, motor_on, pattern_phase, surface_active, engine_running,
             engine_period_valid, engine_period_us,
      input  ready
   );

   modport sink (
      input  valid, motor_on, pattern_phase, surface_active, engine_running,
             engine_period_valid, engine_period_us,
      output ready
   );
endinterface

// ===== sv/rpps_ctrl.sv =====
module rpps_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rpps_pkg::ctl_type ctl
);
   import rpps_pkg::*;

   fsm_type state_ff;
   fsm_type state_in;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   logic    out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_MUL1;
         end
         ST_MUL1:   state_in = ST_MUL2;
         ST_MUL2:   state_in = ST_COMMIT;
         ST_COMMIT: begin
            // hold until the output register can take the response
            if (out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = (state_ff == ST_IDLE);
      ctl.capture = (state_ff == ST_IDLE) && req_valid;
      ctl.stage1  = (state_ff == ST_MUL1);
      ctl.stage2  = (state_ff == ST_MUL2);
      ctl.commit  = (state_ff == ST_COMMIT) && out_free;
   end

   always_comb begin
      priority if (ctl.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      ctl.commit |=> rsp_valid_ff)
      else $error("response not presented after commit");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_MUL1)
      else $error("accepted request did not start the multiply chain");

   a_commit_stalls: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COMMIT && rsp_valid_ff && !rsp_ready |=> state_ff == ST_COMMIT)
      else $error("commit overran a pending response");
`endif

endmodule

// ===== sv/rpps_dp.sv =====
module rpps_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rpps_pkg::ctl_type                    ctl,
   input  logic                                 csr_we,
   input  logic [rpps_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rpps_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [rpps_pkg::CMD_W-1:0]           req_command,
   input  logic [rpps_pkg::ELAPSED_W-1:0]       req_elapsed_ms,
   input  logic signed [rpps_pkg::SPEED_W-1:0]  req_forward_speed,
   input  logic [rpps_pkg::TURBO_W-1:0]         req_turbo_level,
   input  logic [rpps_pkg::LEVEL_W-1:0]         req_intensity,
   output logic                                 rsp_motor_on,
   output logic [1:0]                           rsp_pattern_phase,
   output logic                                 rsp_surface_active,
   output logic                                 rsp_engine_running,
   output logic                                 rsp_engine_period_valid,
   output logic [rpps_pkg::PERIOD_W-1:0]        rsp_engine_period_us
);
   import rpps_pkg::*;

   // Configuration
   logic dev_ff;
   logic eep_ff;

   // Captured request
   logic [CMD_W-1:0]     cmd_ff;
   logic [ELAPSED_W-1:0] elapsed_ff;
   logic [TURBO_W-1:0]   turbo_ff;
   logic [LEVEL_W-1:0]   inten_ff;
   logic [U_W-1:0]       u_ff;
   logic                 fast_ff;
   logic [MAG_W-1:0]     mag_ff;

   // Multiply chain
   logic [UU_W-1:0]      uu_ff;
   logic [PER_W-1:0]     per_ff;
   logic [TIME_W-1:0]    pulse_ff;
   logic [PERIOD_W-1:0]  period_ff;

   // Pattern state
   phase_type            phase_ff,  phase_in;
   logic [TOTAL_W-1:0]   total_ff,  total_in;
   logic [TIME_W-1:0]    pleft_ff,  pleft_in;
   logic [TIME_W-1:0]    on_ff,     on_in;
   logic [TIME_W-1:0]    off_ff,    off_in;
   logic                 surf_ff,   surf_in;
   logic [LEVEL_W-1:0]   lvl_ff,    lvl_in;
   logic                 eng_ff,    eng_in;
   logic                 motor_ff,  motor_in;
   logic                 pvalid_in;
   logic [PERIOD_W-1:0]  period_in;

   // Speed magnitude and ratio from the incoming request
   logic [SPEED_W:0]     speed_mag;
   logic [SPEED_W+2:0]   u5;
   logic                 u_fast;
   logic [U_W-1:0]       u_val;

   // Stage 2 products
   logic [PROD_W-1:0]    prod;
   logic                 pulse_low;
   logic [PER_W:0]       per_rnd;
   logic [PERIOD_W:0]    per_div;

   always_comb begin
      speed_mag = req_forward_speed[SPEED_W-1]
                ? (SPEED_W+1)'((SPEED_W+1)'(1 << SPEED_W) - {1'b0, req_forward_speed})
                : {1'b0, req_forward_speed};
      u5     = {speed_mag, 2'b00} + (SPEED_W+3)'(speed_mag);
      u_fast = u5 > (SPEED_W+3)'(SPEED_FULL);
      u_val  = u_fast ? U_W'(SPEED_FULL) : u5[U_W-1:0];
   end

   always_comb begin
      prod      = PROD_W'(uu_ff) * PROD_W'(times20(lvl_ff));
      pulse_low = uu_ff < UU_W'(SURF_MIN_SQ);
      // ceiling of magnitude * 15625 / 64
      per_rnd   = (PER_W+1)'(per_ff) + (PER_W+1)'((1 << PERIOD_SHIFT) - 1);
      per_div   = (PERIOD_W+1)'(per_rnd[PER_W:PERIOD_SHIFT]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_ff <= 1'b0;
         eep_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEVICE_PRESENT: dev_ff <= csr_wdata[0];
            CSR_ENGINE_EFFECT:  eep_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff     <= req_command;
         elapsed_ff <= req_elapsed_ms;
         turbo_ff   <= req_turbo_level;
         inten_ff   <= req_intensity;
         u_ff       <= u_val;
         fast_ff    <= u_fast;
         mag_ff     <= speed_mag[MAG_W-1:0];
      end
      if (ctl.stage1) begin
         uu_ff  <= UU_W'(u_ff) * UU_W'(u_ff);
         per_ff <= PER_W'(mag_ff) * PER_W'(PERIOD_SCALE);
      end
      if (ctl.stage2) begin
         pulse_ff  <= pulse_low ? '0 : TIME_W'(prod[PROD_W-1:32]);
         period_ff <= fast_ff ? '0
                    : PERIOD_W'((PERIOD_W+1)'(PERIOD_MAX) - per_div);
      end
   end

   always_comb begin
      logic [TIME_W-1:0] on_cur;
      logic [TIME_W-1:0] pl_sub;

      phase_in  = phase_ff;
      total_in  = total_ff;
      pleft_in  = pleft_ff;
      on_in     = on_ff;
      off_in    = off_ff;
      surf_in   = surf_ff;
      lvl_in    = lvl_ff;
      eng_in    = eng_ff;
      motor_in  = motor_ff;
      pvalid_in = 1'b0;
      period_in = '0;
      on_cur    = surf_ff ? pulse_ff : on_ff;
      pl_sub    = (elapsed_ff > pleft_ff) ? '0 : pleft_ff - elapsed_ff;

      unique case (cmd_ff)
         CMD_TICK: begin
            if (dev_ff && eep_ff && eng_ff) begin
               pvalid_in = 1'b1;
               period_in = period_ff;
            end
            if (dev_ff && phase_ff != PH_IDLE) begin
               on_in = on_cur;
               if (TOTAL_W'(elapsed_ff) >= total_ff) begin
                  // pattern ends; restart the surface rumble if a level is set
                  motor_in = 1'b0;
                  total_in = '0;
                  pleft_in = '0;
                  on_in    = '0;
                  off_in   = '0;
                  phase_in = PH_IDLE;
                  if (lvl_ff != '0) begin
                     surf_in  = 1'b1;
                     total_in = ENDLESS_MS;
                     on_in    = surf_start_on(lvl_ff);
                     off_in   = SURFACE_OFF_MS;
                     phase_in = PH_OFF;
                  end
               end else begin
                  total_in = total_ff - TOTAL_W'(elapsed_ff);
                  pleft_in = pl_sub;
                  if (pl_sub == '0) begin
                     if (phase_ff == PH_OFF && on_cur != '0) begin
                        motor_in = 1'b1;
                        phase_in = PH_ON;
                        pleft_in = on_cur;
                     end else begin
                        motor_in = 1'b0;
                        phase_in = PH_OFF;
                        pleft_in = off_ff;
                     end
                  end
               end
            end
         end
         CMD_TURBO, CMD_REACTION, CMD_LIGHT, CMD_SCRAPE: begin
            if (dev_ff && (cmd_ff != CMD_SCRAPE || phase_ff == PH_IDLE)) begin
               phase_in = PH_OFF;
               surf_in  = 1'b0;
               off_in   = NO_OFF;
               priority case (cmd_ff)
                  CMD_REACTION: begin
                     total_in = REACT_TOTAL;
                     on_in    = REACT_ON;
                  end
                  CMD_LIGHT: begin
                     total_in = LIGHT_TOTAL;
                     on_in    = LIGHT_ON;
                  end
                  CMD_SCRAPE: begin
                     total_in = SCRAPE_TOTAL;
                     on_in    = SCRAPE_ON;
                  end
                  default: begin
                     unique case (turbo_ff)
                        2'd0: begin
                           total_in = TURBO0_TOTAL;
                           on_in    = TURBO0_ON;
                        end
                        2'd1: begin
                           total_in = TURBO1_TOTAL;
                           on_in    = TURBO1_ON;
                        end
                        2'd2: begin
                           total_in = TURBO2_TOTAL;
                           on_in    = TURBO2_ON;
                           off_in   = TURBO2_OFF;
                        end
                        default: begin
                           total_in = TURBO3_TOTAL;
                           on_in    = TURBO3_ON;
                        end
                     endcase
                  end
               endcase
            end
         end
         CMD_SET_LVL: begin
            lvl_in = inten_ff;
            if (inten_ff == '0 && surf_ff) begin
               // drop the surface rumble and stop the running pattern
               surf_in = 1'b0;
               if (dev_ff && phase_ff != PH_IDLE) begin
                  motor_in = 1'b0;
                  total_in = '0;
                  pleft_in = '0;
                  on_in    = '0;
                  off_in   = '0;
                  phase_in = PH_IDLE;
               end
            end else if (phase_ff == PH_IDLE) begin
               surf_in  = 1'b1;
               total_in = ENDLESS_MS;
               on_in    = surf_start_on(inten_ff);
               off_in   = SURFACE_OFF_MS;
               pleft_in = '0;
               phase_in = PH_OFF;
            end
         end
         CMD_ENG_ON:  eng_in = 1'b1;
         CMD_ENG_OFF: eng_in = 1'b0;
         CMD_PAUSE: begin
            if (dev_ff) motor_in = 1'b0;
         end
         CMD_RESUME: begin
            if (dev_ff && phase_ff == PH_ON) motor_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         total_ff <= '0;
         pleft_ff <= '0;
         on_ff    <= '0;
         off_ff   <= '0;
         surf_ff  <= 1'b0;
         lvl_ff   <= '0;
         eng_ff   <= 1'b0;
         motor_ff <= 1'b0;
      end else if (ctl.commit) begin
         phase_ff <= phase_in;
         total_ff <= total_in;
         pleft_ff <= pleft_in;
         on_ff    <= on_in;
         off_ff   <= off_in;
         surf_ff  <= surf_in;
         lvl_ff   <= lvl_in;
         eng_ff   <= eng_in;
         motor_ff <= motor_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         rsp_motor_on            <= motor_in;
         rsp_pattern_phase       <= phase_in;
         rsp_surface_active      <= surf_in;
         rsp_engine_running      <= eng_in & eep_ff;
         rsp_engine_period_valid <= pvalid_in;
         rsp_engine_period_us    <= period_in;
      end
   end

`ifndef SYNTHESIS
   a_idle_motor_off: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> !motor_ff)
      else $error("motor driven while no pattern runs");
`endif

endmodule

// ===== sv/rumble_pulse_pattern_sequencer.sv =====
// Rumble motor pulse sequencer: each request (tick, preset burst, surface
// intensity, engine start/stop, pause, resume) yields exactly one response
// with the motor level, pattern phase, surface and engine flags and, on a
// tick with the device present and the engine running, the new engine sine
// period in microseconds. A request is captured on acceptance, then states
// ST_MUL1 and ST_MUL2 run the registered multiply chain (speed ratio
// squared, then times the surface intensity, alongside the engine period
// scaling), and ST_COMMIT updates the pattern state and loads the response.
// A new request is taken only once the previous one has committed. The
// response sits in an output register, so the next request is accepted
// while it waits; a stalled response holds the state update. Registers are
// to be written through csr_we/csr_index/csr_wdata only while no request
// is in flight, which the block itself does not enforce: index 0 device
// present, index 1 engine effect present.
module rumble_pulse_pattern_sequencer (
   input  logic                              clock,
   input  logic                              reset,
   rpps_req_if.sink                          req,
   rpps_rsp_if.source                        rsp,
   input  logic                              csr_we,
   input  logic [rpps_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rpps_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rpps_pkg::*;

   ctl_type ctl;

   rpps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .ctl       (ctl)
   );

   rpps_dp u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .ctl                     (ctl),
      .csr_we                  (csr_we),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata),
      .req_command             (req.command),
      .req_elapsed_ms          (req.elapsed_ms),
      .req_forward_speed       (req.forward_speed),
      .req_turbo_level         (req.turbo_level),
      .req_intensity           (req.intensity),
      .rsp_motor_on            (rsp.motor_on),
      .rsp_pattern_phase       (rsp.pattern_phase),
      .rsp_surface_active      (rsp.surface_active),
      .rsp_engine_running      (rsp.engine_running),
      .rsp_engine_period_valid (rsp.engine_period_valid),
      .rsp_engine_period_us    (rsp.engine_period_us)
   );

endmodule
